[rtl/bounded_lifo_stack_with_search_assert.svh]
// Assertion macros for the bounded LIFO stack RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef BOUNDED_LIFO_STACK_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_LIFO_STACK_WITH_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every clock edge, suspended while reset is asserted.
`define BLIFO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked on every clock edge, including during reset.
`define BLIFO_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BLIFO_ASSERT(lbl, prop, msg)
`define BLIFO_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/blifo_pkg.sv]
// Shared types and constants for the bounded LIFO stack with search.
// No dependencies; used by the top level.
package blifo_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;
	localparam int FIDX_W = 4;
	localparam int ECNT_W = 5;
	localparam int OUT_DATA_W = 48;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

endpackage

[rtl/blifo_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module blifo_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/bounded_lifo_stack_with_search.sv]
// Top level of the bounded LIFO stack with search: request sequencer and output register.
// Depends on blifo_pkg, blifo_ram and bounded_lifo_stack_with_search_assert.svh.
//
// Channel   Dir  Handshake                    Contents
// s_axis    in   tvalid/tready                tdata: in_value; tuser: req_type
// m_axis    out  tvalid/tready                tdata: out_value, found_index, element_count,
//                                             is_empty; tuser: status
// cfg       in   cfg_we (no back-pressure)    cfg_wdata: stack_capacity
//
// Push, failed pop, empty search and no-op requests go from idle straight to the
// emit state; a pop first passes the pop state, since the top entry is read from
// the entry RAM's read register. A search reads one entry per cycle from the bottom
// and compares at most the element count of entries before the emit state.
// One request is in flight at a time; s_axis_tready is high only when idle.
// A result waits in the output register while m_axis_tready is low.
// Reset empties the stack and sets the capacity to 16; the RAM needs no clearing.
`include "bounded_lifo_stack_with_search_assert.svh"

module bounded_lifo_stack_with_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] in_value
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] out_value, [35:32] found_index,
	                                    // [40:36] element_count, [41] is_empty
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata       // stack_capacity
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP  = 4'b0010,
		S_SRCH = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [blifo_pkg::CNT_W-1:0]  count_q, count_d;
	logic [blifo_pkg::CAP_W-1:0]  cap_q;
	logic [blifo_pkg::IDX_W-1:0]  idx_q, idx_d;
	logic [blifo_pkg::DATA_W-1:0] key_q, key_d;
	logic [blifo_pkg::DATA_W-1:0] res_value_q, res_value_d;
	logic [blifo_pkg::FIDX_W-1:0] res_idx_q, res_idx_d;
	blifo_pkg::status_t           res_status_q, res_status_d;

	logic                             m_valid_q;
	logic [blifo_pkg::OUT_DATA_W-1:0] m_data_q;
	logic [1:0]                       m_user_q;

	logic                         ram_wr_en, ram_rd_en;
	logic [blifo_pkg::IDX_W-1:0]  ram_wr_addr, ram_rd_addr;
	logic [blifo_pkg::DATA_W-1:0] ram_rd_data;

	logic               s_fire, out_free, stack_full, stack_empty, last_entry;
	blifo_pkg::req_t    req;

	assign s_fire      = s_axis_tvalid && s_axis_tready;
	assign out_free    = !m_valid_q || m_axis_tready;
	assign req         = blifo_pkg::req_t'(s_axis_tuser);
	// The capacity register may exceed the built depth; both bounds apply.
	assign stack_full  = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= blifo_pkg::DEPTH);
	assign stack_empty = (count_q == '0);
	assign last_entry  = (32'(idx_q) + 32'd1 == 32'(count_q));

	assign s_axis_tready = (state_q == S_IDLE);

	blifo_ram #(
		.DEPTH (blifo_pkg::DEPTH),
		.WIDTH (blifo_pkg::DATA_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (s_axis_tdata),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		key_d        = key_q;
		res_value_d  = res_value_q;
		res_idx_d    = res_idx_q;
		res_status_d = res_status_q;
		ram_wr_en    = 1'b0;
		ram_wr_addr  = count_q[blifo_pkg::IDX_W-1:0];
		ram_rd_en    = 1'b0;
		ram_rd_addr  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					res_value_d  = '0;
					res_idx_d    = '0;
					res_status_d = blifo_pkg::ST_OK;
					key_d        = s_axis_tdata;
					idx_d        = '0;
					state_d      = S_EMIT;
					unique case (req)
						blifo_pkg::REQ_PUSH: begin
							if (stack_full) begin
								res_status_d = blifo_pkg::ST_OVERFLOW;
							end else begin
								ram_wr_en = 1'b1;
								count_d   = count_q + 1'b1;
							end
						end
						blifo_pkg::REQ_POP: begin
							if (stack_empty) begin
								res_status_d = blifo_pkg::ST_UNDERFLOW;
							end else begin
								ram_rd_en   = 1'b1;
								ram_rd_addr = blifo_pkg::IDX_W'(count_q - 1'b1);
								count_d     = count_q - 1'b1;
								state_d     = S_POP;
							end
						end
						blifo_pkg::REQ_SEARCH: begin
							if (stack_empty) begin
								res_status_d = blifo_pkg::ST_NOT_FOUND;
							end else begin
								ram_rd_en   = 1'b1;
								ram_rd_addr = '0;
								state_d     = S_SRCH;
							end
						end
						blifo_pkg::REQ_NOP: begin
						end
						default: begin
						end
					endcase
				end
			end
			S_POP: begin
				res_value_d = ram_rd_data;
				state_d     = S_EMIT;
			end
			S_SRCH: begin
				// Read data holds the entry at idx_q; a miss before the last fetches the next.
				if (ram_rd_data == key_q) begin
					res_idx_d    = blifo_pkg::FIDX_W'(idx_q);
					res_status_d = blifo_pkg::ST_OK;
					state_d      = S_EMIT;
				end else if (last_entry) begin
					res_status_d = blifo_pkg::ST_NOT_FOUND;
					state_d      = S_EMIT;
				end else begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = idx_q + 1'b1;
					idx_d       = idx_q + 1'b1;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cap_q     <= blifo_pkg::CAP_RESET;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (state_q == S_EMIT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		key_q        <= key_d;
		res_value_q  <= res_value_d;
		res_idx_q    <= res_idx_d;
		res_status_q <= res_status_d;
		if (state_q == S_EMIT && out_free) begin
			m_data_q <= {6'd0, stack_empty, blifo_pkg::ECNT_W'(count_q), res_idx_q, res_value_q};
			m_user_q <= res_status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	`BLIFO_ASSERT(a_count_bound, 32'(count_q) <= blifo_pkg::DEPTH,
		"element count above depth")
	`BLIFO_ASSERT(a_push_grows,
		s_fire && req == blifo_pkg::REQ_PUSH && !stack_full
			|=> count_q == blifo_pkg::CNT_W'($past(count_q) + 1'b1),
		"push did not grow the count")
	`BLIFO_ASSERT(a_underflow_empty,
		m_axis_tvalid && m_axis_tuser == blifo_pkg::ST_UNDERFLOW |-> m_axis_tdata[40:36] == 5'd0,
		"underflow reported on a non-empty stack")
	`BLIFO_ASSERT(a_search_in_range, state_q == S_SRCH |-> 32'(idx_q) < 32'(count_q),
		"search index beyond element count")

endmodule
